// ----- src/dssq_pkg.sv -----
// Shared constants, types and codes for the deadline sorted sleep queue.
package dssq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TICK_W      = 64;
    localparam int ID_W        = 8;
    localparam int COUNT_W     = 32;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_SLEEP = 1'b1
    } cmd_t;

    typedef enum logic {
        STAT_WOKEN    = 1'b0,
        STAT_REJECTED = 1'b1
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_REJECT,
        ST_RELEASE
    } state_t;

    typedef struct packed {
        logic              valid;
        logic              keep;
        logic [TICK_W-1:0] wake;
        logic [ID_W-1:0]   thread;
    } cell_link_t;

endpackage

// ----- src/dssq_cell.sv -----
// One queue slot: holds an entry, compares it to the broadcast key, trades with neighbors.
module dssq_cell
    import dssq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_op_t          op,
    input  logic [TICK_W-1:0] key,
    input  logic [ID_W-1:0]   new_thread,
    input  cell_link_t        prev_link,
    input  cell_link_t        next_link,
    output cell_link_t        link
);

    logic              valid_reg;
    logic              valid_next;
    logic [TICK_W-1:0] wake_reg;
    logic [TICK_W-1:0] wake_next;
    logic [ID_W-1:0]   thread_reg;
    logic [ID_W-1:0]   thread_next;
    logic              keep;

    assign keep = valid_reg && (wake_reg <= key);

    always_comb
    begin
        valid_next  = valid_reg;
        wake_next   = wake_reg;
        thread_next = thread_reg;
        unique case (op)
            OP_HOLD:
            begin
            end
            OP_INSERT:
            begin
                if (!keep)
                begin
                    if (prev_link.keep)
                    begin
                        valid_next  = 1'b1;
                        wake_next   = key;
                        thread_next = new_thread;
                    end
                    else
                    begin
                        valid_next  = prev_link.valid;
                        wake_next   = prev_link.wake;
                        thread_next = prev_link.thread;
                    end
                end
            end
            OP_SHIFT:
            begin
                valid_next  = next_link.valid;
                wake_next   = next_link.wake;
                thread_next = next_link.thread;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wake_reg   <= wake_next;
        thread_reg <= thread_next;
    end

    assign link.valid  = valid_reg;
    assign link.keep   = keep;
    assign link.wake   = wake_reg;
    assign link.thread = thread_reg;

endmodule

// ----- src/deadline_sorted_sleep_queue.sv -----
// Top level: tick counter, command sequencer, row of queue cells and result register.
//
// Input channel (in_valid / in_stall): command, thread_id, sleep_ticks. A tick
// (command 0) advances the 64-bit tick count; a sleep request (command 1) with a
// nonzero count enters the sorted queue with wake time count plus sleep_ticks,
// saturating, behind entries of equal wake time.
// Output channel (out_valid / out_stall): status, woken_id, last_of_run. A tick
// releases every due entry from the head, one item per cycle unless the receiver
// stalls, last_of_run on the final one. A nonzero request on a full queue gives
// one item with status 1. A sleep request is accepted, then in the insert state
// every cell compares against the new wake time in parallel and the cells behind
// the new entry shift down. After a tick the head cell releases one per cycle.
// A zero-count request is accepted and dropped. in_stall stays high until the
// item is done. Receiver stall holds the result register and pauses release or
// reject. Reset clears the tick count, the queue and out_valid; no warm-up.
module deadline_sorted_sleep_queue
    import dssq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [ID_W-1:0]    thread_id,
    input  logic [COUNT_W-1:0] sleep_ticks,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic [ID_W-1:0]    woken_id,
    output logic               last_of_run
);

    state_t             state_reg;
    state_t             state_next;
    logic [TICK_W-1:0]  tick_reg;
    logic [TICK_W-1:0]  tick_next;
    logic [TICK_W-1:0]  key_reg;
    logic [TICK_W-1:0]  key_next;
    logic [ID_W-1:0]    id_reg;
    logic [ID_W-1:0]    id_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_status_reg;
    logic               out_status_next;
    logic [ID_W-1:0]    out_id_reg;
    logic [ID_W-1:0]    out_id_next;
    logic               out_last_reg;
    logic               out_last_next;

    cell_op_t           op;
    logic [TICK_W-1:0]  key;
    logic [TICK_W:0]    wake_sum;
    logic [TICK_W-1:0]  wake_sat;
    logic               in_fire;
    logic               out_free;
    logic               full;
    cell_link_t         links [0:QUEUE_DEPTH];
    cell_link_t         boundary;

    assign boundary = '{valid: 1'b1, keep: 1'b1, wake: '0, thread: '0};
    assign links[QUEUE_DEPTH] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            dssq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (op),
                .key        (key),
                .new_thread (id_reg),
                .prev_link  ((gi == 0) ? boundary : links[(gi == 0) ? 0 : gi-1]),
                .next_link  (links[gi+1]),
                .link       (links[gi])
            );
        end
    endgenerate

    assign full     = links[QUEUE_DEPTH-1].valid;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign key      = (state_reg == ST_INSERT) ? key_reg : tick_reg;
    assign wake_sum = {1'b0, tick_reg} + {{(TICK_W+1-COUNT_W){1'b0}}, sleep_ticks};
    assign wake_sat = wake_sum[TICK_W] ? {TICK_W{1'b1}} : wake_sum[TICK_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        key_next        = key_reg;
        id_next         = id_reg;
        op              = OP_HOLD;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (command == CMD_SLEEP)
                    begin
                        id_next = thread_id;
                        if (sleep_ticks != '0)
                        begin
                            if (full)
                            begin
                                state_next = ST_REJECT;
                            end
                            else
                            begin
                                key_next   = wake_sat;
                                state_next = ST_INSERT;
                            end
                        end
                    end
                    else
                    begin
                        tick_next  = tick_reg + TICK_W'(1);
                        state_next = ST_RELEASE;
                    end
                end
            end
            ST_INSERT:
            begin
                op         = OP_INSERT;
                state_next = ST_IDLE;
            end
            ST_REJECT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_REJECTED;
                    out_id_next     = id_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_RELEASE:
            begin
                if (!links[0].keep)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    op              = OP_SHIFT;
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_WOKEN;
                    out_id_next     = links[0].thread;
                    out_last_next   = !links[1].keep;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        id_reg         <= id_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign woken_id    = out_id_reg;
    assign last_of_run = out_last_reg;

endmodule
